// ----- src/rti_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rti_pkg
// Shared types, widths and arithmetic helpers for the ray/triangle unit.
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int CW  = 24;   // coordinate field width
  localparam int IW  = 10;   // index field width
  localparam int IXW = 17;   // index width able to hold any depth
  localparam int EW  = 25;   // edge / difference width
  localparam int PW  = 51;   // cross product width
  localparam int DW  = 80;   // dot product width
  localparam int QW  = 32;   // distance width
  localparam int FW  = 3 * IW;

  localparam logic CFG_DET_MIN = 1'b0;
  localparam logic CFG_T_MIN   = 1'b1;

  typedef enum logic [1:0] {
    CMD_VERTEX = 2'd0,
    CMD_FACE   = 2'd1,
    CMD_TRACE  = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [1:0]    command;
    logic [IW-1:0] entry_index;
    logic [CW-1:0] coord_x;
    logic [CW-1:0] coord_y;
    logic [CW-1:0] coord_z;
    logic [CW-1:0] dir_x;
    logic [CW-1:0] dir_y;
    logic [CW-1:0] dir_z;
    logic [IW-1:0] corner_a;
    logic [IW-1:0] corner_b;
    logic [IW-1:0] corner_c;
  } req_t;

  typedef struct packed {
    logic signed [EW-1:0] x;
    logic signed [EW-1:0] y;
    logic signed [EW-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [PW-1:0] x;
    logic signed [PW-1:0] y;
    logic signed [PW-1:0] z;
  } wvec_t;

  typedef struct packed {
    logic v;
    logic ok;
    vec_t pa;
    vec_t pb;
    vec_t pc;
    vec_t org;
    vec_t dir;
  } geo_in_t;

  typedef struct packed {
    logic          v;
    logic          ok;
    logic          sat;
    logic [DW-1:0] num;
    logic [DW-1:0] det;
    wvec_t         nrm;
  } div_in_t;

  typedef struct packed {
    logic          v;
    logic          ok;
    logic          sat;
    logic [DW-1:0] rem;
    logic [QW-1:0] low;
    logic [QW-1:0] quo;
    logic [DW-1:0] det;
    wvec_t         nrm;
  } dstage_t;

  typedef struct packed {
    logic                 hit;
    logic [QW-1:0]        distance;
    logic signed [PW-1:0] normal_x;
    logic signed [PW-1:0] normal_y;
    logic signed [PW-1:0] normal_z;
  } res_t;

  function automatic logic signed [2*EW-1:0] mul_ee(logic signed [EW-1:0] a,
                                                   logic signed [EW-1:0] b);
    return (2*EW)'(a) * (2*EW)'(b);
  endfunction

  function automatic logic signed [PW-1:0] sub_pp(logic signed [2*EW-1:0] a,
                                                 logic signed [2*EW-1:0] b);
    return PW'(a) - PW'(b);
  endfunction

  // 25 x 26 partial product of a dot term
  function automatic logic signed [PW-1:0] mul_part(logic signed [EW-1:0] a,
                                                   logic signed [EW:0] b);
    return PW'(a) * PW'(b);
  endfunction

  function automatic logic [DW-1:0] join_part(logic signed [PW-1:0] hp,
                                              logic signed [PW-1:0] lp);
    logic signed [DW-1:0] h;
    logic signed [DW-1:0] l;
    h = DW'(hp);
    l = DW'(lp);
    return (h <<< EW) + l;
  endfunction

endpackage
`default_nettype wire

// ----- src/rti_store.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rti_store
// Face table and three vertex table copies; fetches the three corners.
// ----------------------------------------------------------------------------
module rti_store #(
  parameter int VERTEX_DEPTH = 1024,
  parameter int FACE_DEPTH   = 1024,
  parameter int COORD_BITS   = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             req_v,
  input  rti_pkg::req_t    req,
  output rti_pkg::geo_in_t geo
);

  localparam int IW   = rti_pkg::IW;
  localparam int IXW  = rti_pkg::IXW;
  localparam int EW   = rti_pkg::EW;
  localparam int VA_W = $clog2(VERTEX_DEPTH);
  localparam int FA_W = (FACE_DEPTH > 1) ? $clog2(FACE_DEPTH) : 1;
  localparam int VW   = 3 * COORD_BITS;

  logic [VW-1:0]          vmem_a [VERTEX_DEPTH];
  logic [VW-1:0]          vmem_b [VERTEX_DEPTH];
  logic [VW-1:0]          vmem_c [VERTEX_DEPTH];
  logic [rti_pkg::FW-1:0] fmem   [FACE_DEPTH];

  logic [IXW-1:0] slot_ext;
  logic           vslot_ok;
  logic           fslot_ok;
  logic [VW-1:0]  vword;

  logic                   s1_v;
  logic                   s1_ok;
  rti_pkg::vec_t          s1_org;
  rti_pkg::vec_t          s1_dir;
  logic [rti_pkg::FW-1:0] face_q;

  logic [IXW-1:0] ca_ext;
  logic [IXW-1:0] cb_ext;
  logic [IXW-1:0] cc_ext;
  logic           corners_ok;

  logic          s2_v;
  logic          s2_ok;
  rti_pkg::vec_t s2_org;
  rti_pkg::vec_t s2_dir;
  logic [VW-1:0] ra;
  logic [VW-1:0] rb;
  logic [VW-1:0] rc;

  function automatic logic signed [EW-1:0] sx(logic [COORD_BITS-1:0] w);
    return EW'($signed(w));
  endfunction

  function automatic rti_pkg::vec_t unpack_v(logic [VW-1:0] w);
    rti_pkg::vec_t r;
    r.x = sx(w[COORD_BITS-1:0]);
    r.y = sx(w[2*COORD_BITS-1:COORD_BITS]);
    r.z = sx(w[3*COORD_BITS-1:2*COORD_BITS]);
    return r;
  endfunction

  assign slot_ext = IXW'(req.entry_index);
  assign vslot_ok = 32'(req.entry_index) < 32'(VERTEX_DEPTH);
  assign fslot_ok = 32'(req.entry_index) < 32'(FACE_DEPTH);
  assign vword    = {req.coord_z[COORD_BITS-1:0], req.coord_y[COORD_BITS-1:0],
                     req.coord_x[COORD_BITS-1:0]};

  assign ca_ext = IXW'(face_q[IW-1:0]);
  assign cb_ext = IXW'(face_q[2*IW-1:IW]);
  assign cc_ext = IXW'(face_q[3*IW-1:2*IW]);
  assign corners_ok = (32'(face_q[IW-1:0]) < 32'(VERTEX_DEPTH)) &&
                      (32'(face_q[2*IW-1:IW]) < 32'(VERTEX_DEPTH)) &&
                      (32'(face_q[3*IW-1:2*IW]) < 32'(VERTEX_DEPTH));

  // table writes
  always_ff @(posedge clk) begin
    if (req_v && req.command == rti_pkg::CMD_VERTEX && vslot_ok) begin
      vmem_a[slot_ext[VA_W-1:0]] <= vword;
      vmem_b[slot_ext[VA_W-1:0]] <= vword;
      vmem_c[slot_ext[VA_W-1:0]] <= vword;
    end
    if (req_v && req.command == rti_pkg::CMD_FACE && fslot_ok) begin
      fmem[slot_ext[FA_W-1:0]] <= {req.corner_c, req.corner_b, req.corner_a};
    end
  end

  // reads: face, then corners
  always_ff @(posedge clk) begin
    if (en) begin
      face_q <= fmem[slot_ext[FA_W-1:0]];
      s1_ok  <= fslot_ok;
      s1_org <= unpack_v({req.coord_z[COORD_BITS-1:0], req.coord_y[COORD_BITS-1:0],
                          req.coord_x[COORD_BITS-1:0]});
      s1_dir <= unpack_v({req.dir_z[COORD_BITS-1:0], req.dir_y[COORD_BITS-1:0],
                          req.dir_x[COORD_BITS-1:0]});
      ra     <= vmem_a[ca_ext[VA_W-1:0]];
      rb     <= vmem_b[cb_ext[VA_W-1:0]];
      rc     <= vmem_c[cc_ext[VA_W-1:0]];
      s2_ok  <= s1_ok && corners_ok;
      s2_org <= s1_org;
      s2_dir <= s1_dir;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else if (en) begin
      s1_v <= req_v && req.command == rti_pkg::CMD_TRACE;
      s2_v <= s1_v;
    end
  end

  assign geo.v   = s2_v;
  assign geo.ok  = s2_ok;
  assign geo.pa  = unpack_v(ra);
  assign geo.pb  = unpack_v(rb);
  assign geo.pc  = unpack_v(rc);
  assign geo.org = s2_org;
  assign geo.dir = s2_dir;

endmodule
`default_nettype wire

// ----- src/rti_geom.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rti_geom
// Edges, cross products, dot products and the barycentric / front-face tests.
// ----------------------------------------------------------------------------
module rti_geom (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic [31:0]      det_min,
  input  rti_pkg::geo_in_t geo,
  output rti_pkg::div_in_t dout
);

  localparam int EW = rti_pkg::EW;
  localparam int PW = rti_pkg::PW;
  localparam int DW = rti_pkg::DW;
  localparam int NS = 6;

  logic [NS:1] sv;
  logic [NS:1] sok;

  rti_pkg::vec_t g1_e1, g1_e2, g1_tv, g1_dv;
  rti_pkg::vec_t g2_e1, g2_e2, g2_tv, g2_dv;
  rti_pkg::vec_t g3_e1, g3_e2, g3_tv, g3_dv;
  logic signed [2*EW-1:0] g2_p [3][6];
  rti_pkg::wvec_t g3_c [3];
  rti_pkg::wvec_t g4_n, g5_n, g6_n;
  logic signed [PW-1:0] g4_hp [4][3];
  logic signed [PW-1:0] g4_lp [4][3];
  logic [DW-1:0] g5_t [4][3];
  logic [DW-1:0] g6_s [4];

  rti_pkg::vec_t  cra [3];
  rti_pkg::vec_t  crb [3];
  logic signed [EW-1:0] opa [4][3];
  logic signed [PW-1:0] opb [4][3];

  logic [DW-1:0] det, bu, bv, num, uv;
  logic          t_ok;

  // crosses: pvec = dir x e2, qvec = tvec x e1, normal = e1 x e2
  always_comb begin
    cra[0] = g1_dv; crb[0] = g1_e2;
    cra[1] = g1_tv; crb[1] = g1_e1;
    cra[2] = g1_e1; crb[2] = g1_e2;
  end

  // dots: det = e1.p, u = t.p, v = d.q, num = e2.q
  always_comb begin
    opa[0][0] = g3_e1.x; opa[0][1] = g3_e1.y; opa[0][2] = g3_e1.z;
    opa[1][0] = g3_tv.x; opa[1][1] = g3_tv.y; opa[1][2] = g3_tv.z;
    opa[2][0] = g3_dv.x; opa[2][1] = g3_dv.y; opa[2][2] = g3_dv.z;
    opa[3][0] = g3_e2.x; opa[3][1] = g3_e2.y; opa[3][2] = g3_e2.z;
    opb[0][0] = g3_c[0].x; opb[0][1] = g3_c[0].y; opb[0][2] = g3_c[0].z;
    opb[1][0] = g3_c[0].x; opb[1][1] = g3_c[0].y; opb[1][2] = g3_c[0].z;
    opb[2][0] = g3_c[1].x; opb[2][1] = g3_c[1].y; opb[2][2] = g3_c[1].z;
    opb[3][0] = g3_c[1].x; opb[3][1] = g3_c[1].y; opb[3][2] = g3_c[1].z;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g1_e1.x <= EW'(geo.pb.x - geo.pa.x);
      g1_e1.y <= EW'(geo.pb.y - geo.pa.y);
      g1_e1.z <= EW'(geo.pb.z - geo.pa.z);
      g1_e2.x <= EW'(geo.pc.x - geo.pa.x);
      g1_e2.y <= EW'(geo.pc.y - geo.pa.y);
      g1_e2.z <= EW'(geo.pc.z - geo.pa.z);
      g1_tv.x <= EW'(geo.org.x - geo.pa.x);
      g1_tv.y <= EW'(geo.org.y - geo.pa.y);
      g1_tv.z <= EW'(geo.org.z - geo.pa.z);
      g1_dv   <= geo.dir;

      for (int k = 0; k < 3; k++) begin
        g2_p[k][0] <= rti_pkg::mul_ee(cra[k].y, crb[k].z);
        g2_p[k][1] <= rti_pkg::mul_ee(cra[k].z, crb[k].y);
        g2_p[k][2] <= rti_pkg::mul_ee(cra[k].z, crb[k].x);
        g2_p[k][3] <= rti_pkg::mul_ee(cra[k].x, crb[k].z);
        g2_p[k][4] <= rti_pkg::mul_ee(cra[k].x, crb[k].y);
        g2_p[k][5] <= rti_pkg::mul_ee(cra[k].y, crb[k].x);
      end
      g2_e1 <= g1_e1; g2_e2 <= g1_e2; g2_tv <= g1_tv; g2_dv <= g1_dv;

      for (int k = 0; k < 3; k++) begin
        g3_c[k].x <= rti_pkg::sub_pp(g2_p[k][0], g2_p[k][1]);
        g3_c[k].y <= rti_pkg::sub_pp(g2_p[k][2], g2_p[k][3]);
        g3_c[k].z <= rti_pkg::sub_pp(g2_p[k][4], g2_p[k][5]);
      end
      g3_e1 <= g2_e1; g3_e2 <= g2_e2; g3_tv <= g2_tv; g3_dv <= g2_dv;

      // split the 51-bit operand into a signed high and an unsigned low half
      for (int d = 0; d < 4; d++) begin
        for (int k = 0; k < 3; k++) begin
          g4_hp[d][k] <= rti_pkg::mul_part(opa[d][k], opb[d][k][PW-1:EW]);
          g4_lp[d][k] <= rti_pkg::mul_part(opa[d][k], {1'b0, opb[d][k][EW-1:0]});
        end
      end
      g4_n <= g3_c[2];

      for (int d = 0; d < 4; d++) begin
        for (int k = 0; k < 3; k++) begin
          g5_t[d][k] <= rti_pkg::join_part(g4_hp[d][k], g4_lp[d][k]);
        end
      end
      g5_n <= g4_n;

      for (int d = 0; d < 4; d++) begin
        g6_s[d] <= g5_t[d][0] + g5_t[d][1] + g5_t[d][2];
      end
      g6_n <= g5_n;

      dout.ok  <= sok[NS] && t_ok;
      dout.sat <= {16'b0, num} >= {det, 16'b0};
      dout.num <= num;
      dout.det <= det;
      dout.nrm <= g6_n;
    end
  end

  assign det = g6_s[0];
  assign bu  = g6_s[1];
  assign bv  = g6_s[2];
  assign num = g6_s[3];
  assign uv  = bu + bv;
  assign t_ok = !det[DW-1] && det != '0 && det >= DW'(det_min) &&
                !bu[DW-1] && bu <= det &&
                !bv[DW-1] && uv <= det &&
                !num[DW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv     <= '0;
      dout.v <= 1'b0;
    end else if (en) begin
      sv     <= {sv[NS-1:1], geo.v};
      dout.v <= sv[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sok <= {sok[NS-1:1], geo.ok};
    end
  end

endmodule
`default_nettype wire

// ----- src/rti_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rti_div
// Restoring divider, one quotient bit per stage, then the distance test.
// ----------------------------------------------------------------------------
module rti_div (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic [15:0]      t_min,
  input  rti_pkg::div_in_t din,
  output logic             res_v,
  output rti_pkg::res_t    res
);

  localparam int DW = rti_pkg::DW;
  localparam int QW = rti_pkg::QW;

  rti_pkg::dstage_t st  [QW];
  rti_pkg::dstage_t nxt [QW];
  rti_pkg::dstage_t first;
  rti_pkg::dstage_t last;
  logic             hit;

  always_comb begin
    first.v   = din.v;
    first.ok  = din.ok;
    first.sat = din.sat;
    first.rem = din.num >> 16;
    first.low = {din.num[15:0], 16'b0};
    first.quo = '0;
    first.det = din.det;
    first.nrm = din.nrm;
  end

  always_comb begin
    logic [DW-1:0] t;
    for (int i = 0; i < QW; i++) begin
      nxt[i]     = (i == 0) ? first : st[(i == 0) ? 0 : i - 1];
      t          = {nxt[i].rem[DW-2:0], nxt[i].low[QW-1]};
      nxt[i].low = nxt[i].low << 1;
      if (t >= nxt[i].det) begin
        nxt[i].rem = t - nxt[i].det;
        nxt[i].quo = {nxt[i].quo[QW-2:0], 1'b1};
      end else begin
        nxt[i].rem = t;
        nxt[i].quo = {nxt[i].quo[QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QW; i++) begin
        st[i].v <= 1'b0;
      end
      res_v <= 1'b0;
    end else if (en) begin
      for (int i = 0; i < QW; i++) begin
        st[i] <= nxt[i];
      end
      res_v <= last.v;
    end
  end

  assign last = st[QW-1];
  assign hit  = last.ok && (last.sat || last.quo > QW'(t_min) ||
                (last.quo == QW'(t_min) && last.rem != '0));

  always_ff @(posedge clk) begin
    if (en) begin
      res.hit      <= hit;
      res.distance <= !hit ? '0 : (last.sat ? '1 : last.quo);
      res.normal_x <= hit ? last.nrm.x : '0;
      res.normal_y <= hit ? last.nrm.y : '0;
      res.normal_z <= hit ? last.nrm.z : '0;
    end
  end

endmodule
`default_nettype wire

// ----- src/ray_triangle_intersect_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ray_triangle_intersect_top
// Vertex / face tables and a pipelined front-face ray/triangle intersector.
//
//   channel  dir  handshake         payload
//   s_*      in   tvalid / tready   tuser command, tdata request fields
//   m_*      out  tvalid / tready   tdata hit, distance, normal
//   cfg_*    in   cfg_we            cfg_index, cfg_data
//
// One request per cycle while the skid register is empty. A trace result
// passes 2 table reads, 7 geometry stages, 32 divider stages, 1 result
// register and the output register. Table writes take effect at acceptance.
// rst clears the valid bits and the configuration registers; table contents
// are undefined until written. A stalled output parks one result in a skid
// register and holds the whole pipeline, tables included.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_top #(
  parameter int VERTEX_DEPTH = 1024,
  parameter int FACE_DEPTH   = 1024,
  parameter int COORD_BITS   = 24
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // entry_index, coord_x, coord_y, coord_z, dir_x, dir_y, dir_z,
  // corner_a, corner_b, corner_c
  input  logic [183:0] s_tdata,
  // command
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // hit, distance, normal_x, normal_y, normal_z, zero pad
  output logic [191:0] m_tdata,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data
);

  logic [31:0] det_min;
  logic [15:0] t_min;

  rti_pkg::req_t    req;
  logic             req_v;
  logic             en;
  rti_pkg::geo_in_t geo;
  rti_pkg::div_in_t din;
  logic             res_v;
  rti_pkg::res_t    res;

  rti_pkg::res_t out_q;
  rti_pkg::res_t skid_q;
  logic          out_v;
  logic          skid_v;

  assign req.command     = s_tuser;
  assign req.entry_index = s_tdata[9:0];
  assign req.coord_x     = s_tdata[33:10];
  assign req.coord_y     = s_tdata[57:34];
  assign req.coord_z     = s_tdata[81:58];
  assign req.dir_x       = s_tdata[105:82];
  assign req.dir_y       = s_tdata[129:106];
  assign req.dir_z       = s_tdata[153:130];
  assign req.corner_a    = s_tdata[163:154];
  assign req.corner_b    = s_tdata[173:164];
  assign req.corner_c    = s_tdata[183:174];

  assign en       = !skid_v;
  assign s_tready = en;
  assign req_v    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      det_min <= 32'd687195;
      t_min   <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rti_pkg::CFG_DET_MIN: det_min <= cfg_data;
        rti_pkg::CFG_T_MIN:   t_min   <= cfg_data[15:0];
        default:              ;
      endcase
    end
  end

  rti_store #(
    .VERTEX_DEPTH (VERTEX_DEPTH),
    .FACE_DEPTH   (FACE_DEPTH),
    .COORD_BITS   (COORD_BITS)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .req_v (req_v),
    .req   (req),
    .geo   (geo)
  );

  rti_geom u_geom (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .det_min (det_min),
    .geo     (geo),
    .dout    (din)
  );

  rti_div u_div (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .t_min (t_min),
    .din   (din),
    .res_v (res_v),
    .res   (res)
  );

  // output register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (en && res_v) begin
      if (out_v && !m_tready) begin
        skid_v <= 1'b1;
      end else begin
        out_v <= 1'b1;
      end
    end else if (out_v && m_tready) begin
      out_v  <= skid_v;
      skid_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && res_v) begin
      if (out_v && !m_tready) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end else if (out_v && m_tready && skid_v) begin
      out_q <= skid_q;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = {6'b0, out_q.normal_z, out_q.normal_y, out_q.normal_x,
                     out_q.distance, out_q.hit};

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for ray_triangle_intersect_top. A queue-fed driver sends
// vertex writes, face writes, trace requests and unused-command requests in
// random bursts. Well-formed scenes (three vertices, a face, rays mostly aimed inside
// it) are mixed with random traffic. A local predictor does the exact
// front-face intersection test, and a monitor compares every result in order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE = 60;
  localparam int CW = rti_pkg::CW;
  localparam int IW = rti_pkg::IW;
  localparam int PW = rti_pkg::PW;
  localparam int FW = rti_pkg::FW;
  localparam logic [1:0] CMD_NONE = 2'd3;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [183:0] s_tdata;
  logic [1:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [191:0] m_tdata;
  logic         cfg_we;
  logic         cfg_index;
  logic [31:0]  cfg_data;

  ray_triangle_intersect_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // predictor state
  logic signed [CW-1:0] vx [1024];
  logic signed [CW-1:0] vy [1024];
  logic signed [CW-1:0] vz [1024];
  logic [FW-1:0]        faces [1024];
  logic [31:0]          det_min;
  logic [15:0]          t_min;

  rti_pkg::req_t pending [$];
  rti_pkg::res_t hits_due [$];
  rti_pkg::req_t on_bus;
  int   errors;
  int   results_seen;
  int   burst_left;
  int   gap_left;
  int   quiet_cycles;

  function automatic void cross3(input longint a[3], input longint b[3],
                                 output longint r[3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic logic signed [127:0] dot3(input longint a[3], input longint b[3]);
    logic signed [127:0] acc;
    logic signed [127:0] x;
    logic signed [127:0] y;
    acc = 0;
    for (int k = 0; k < 3; k++) begin
      x = a[k];
      y = b[k];
      acc = acc + x * y;
    end
    return acc;
  endfunction

  function automatic rti_pkg::res_t trace_face(rti_pkg::req_t r);
    rti_pkg::res_t res;
    longint pa[3], pb[3], pc[3], org[3], dv[3], e1[3], e2[3], tv[3];
    longint pv[3], qv[3], nrm[3];
    logic signed [127:0] det, u, v, num, scaled, lim, q;
    logic [IW-1:0] ia, ib, ic;
    res = '0;
    ia = faces[r.entry_index][IW-1:0];
    ib = faces[r.entry_index][2*IW-1:IW];
    ic = faces[r.entry_index][3*IW-1:2*IW];
    pa = '{vx[ia], vy[ia], vz[ia]};
    pb = '{vx[ib], vy[ib], vz[ib]};
    pc = '{vx[ic], vy[ic], vz[ic]};
    org = '{$signed(r.coord_x), $signed(r.coord_y), $signed(r.coord_z)};
    dv = '{$signed(r.dir_x), $signed(r.dir_y), $signed(r.dir_z)};
    for (int k = 0; k < 3; k++) begin
      e1[k] = pb[k] - pa[k];
      e2[k] = pc[k] - pa[k];
      tv[k] = org[k] - pa[k];
    end
    cross3(dv, e2, pv);
    det = dot3(e1, pv);
    lim = det_min;
    if (det <= 0 || det < lim) return res;
    u = dot3(tv, pv);
    if (u < 0 || u > det) return res;
    cross3(tv, e1, qv);
    v = dot3(dv, qv);
    if (v < 0 || u + v > det) return res;
    num = dot3(e2, qv);
    if (num < 0) return res;
    scaled = num <<< 16;
    lim = t_min;
    if (det * lim >= scaled) return res;
    if (scaled >= (det <<< 32)) q = 128'hFFFF_FFFF;
    else q = scaled / det;
    cross3(e1, e2, nrm);
    res.hit = 1'b1;
    res.distance = q[31:0];
    res.normal_x = nrm[0][PW-1:0];
    res.normal_y = nrm[1][PW-1:0];
    res.normal_z = nrm[2][PW-1:0];
    return res;
  endfunction

  // driver: bursts of requests separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tuser <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        case (rti_pkg::cmd_t'(on_bus.command))
          rti_pkg::CMD_VERTEX: begin
            vx[on_bus.entry_index] = on_bus.coord_x;
            vy[on_bus.entry_index] = on_bus.coord_y;
            vz[on_bus.entry_index] = on_bus.coord_z;
          end
          rti_pkg::CMD_FACE: faces[on_bus.entry_index] = {on_bus.corner_c,
                                                          on_bus.corner_b,
                                                          on_bus.corner_a};
          rti_pkg::CMD_TRACE: hits_due = {hits_due, trace_face(on_bus)};
          default: ;
        endcase
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (pending.size() > 0) begin
        on_bus = pending.pop_front();
        s_tdata <= {on_bus.corner_c, on_bus.corner_b, on_bus.corner_a, on_bus.dir_z,
                    on_bus.dir_y, on_bus.dir_x, on_bus.coord_z, on_bus.coord_y,
                    on_bus.coord_x, on_bus.entry_index};
        s_tuser <= on_bus.command;
        s_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern picked at random from three modes, one long hold-off
  int  rx_cycle;
  int  rx_mode;
  int  hold_left;
  bit  held_once;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_cycle <= 0;
      rx_mode <= 0;
      hold_left <= 0;
      held_once <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 128 == 0) rx_mode <= $urandom_range(0, 2);
      if (!held_once && results_seen >= 20) begin
        held_once <= 1'b1;
        hold_left <= 400;
        m_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0: m_tready <= 1'b1;
          1: m_tready <= $urandom_range(0, 1);
          default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    rti_pkg::res_t got;
    rti_pkg::res_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.hit = m_tdata[0];
      got.distance = m_tdata[32:1];
      got.normal_x = m_tdata[83:33];
      got.normal_y = m_tdata[134:84];
      got.normal_z = m_tdata[185:135];
      results_seen <= results_seen + 1;
      if (hits_due.size() == 0) begin
        errors <= errors + 1;
        $display("%0t unexpected result: hit %0d dist %h", $time, got.hit, got.distance);
      end else begin
        want = hits_due.pop_front();
        if (got.hit !== want.hit || got.distance !== want.distance ||
            got.normal_x !== want.normal_x || got.normal_y !== want.normal_y ||
            got.normal_z !== want.normal_z) begin
          errors <= errors + 1;
          $display("%0t mismatch: expected hit %0d dist %h n %h %h %h", $time,
                   want.hit, want.distance, want.normal_x, want.normal_y, want.normal_z);
          $display("%0t           actual   hit %0d dist %h n %h %h %h", $time,
                   got.hit, got.distance, got.normal_x, got.normal_y, got.normal_z);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (pending.size() > 0 || hits_due.size() > 0 || s_tvalid) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("ray_triangle_intersect_top regression: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  bit vtx_written [1024];
  int vtx_list [$];
  int face_list [$];

  function automatic rti_pkg::req_t mk(rti_pkg::cmd_t c, int idx, longint x, longint y,
                                       longint z, longint dx, longint dy, longint dz,
                                       int a = 0, int b = 0, int cc = 0);
    rti_pkg::req_t r;
    r.command = c;
    r.entry_index = idx[IW-1:0];
    r.coord_x = x[CW-1:0];
    r.coord_y = y[CW-1:0];
    r.coord_z = z[CW-1:0];
    r.dir_x = dx[CW-1:0];
    r.dir_y = dy[CW-1:0];
    r.dir_z = dz[CW-1:0];
    r.corner_a = a[IW-1:0];
    r.corner_b = b[IW-1:0];
    r.corner_c = cc[IW-1:0];
    return r;
  endfunction

  task automatic put(rti_pkg::req_t r);
    pending = {pending, r};
    if (rti_pkg::cmd_t'(r.command) == rti_pkg::CMD_VERTEX && !vtx_written[r.entry_index])
    begin
      vtx_written[r.entry_index] = 1'b1;
      vtx_list = {vtx_list, int'(r.entry_index)};
    end
    if (rti_pkg::cmd_t'(r.command) == rti_pkg::CMD_FACE)
      face_list = {face_list, int'(r.entry_index)};
  endtask

  function automatic longint rnd_coord(int mag);
    return longint'($urandom_range(0, 2 * mag)) - mag;
  endfunction

  function automatic int rnd_vtx();
    return vtx_list[$urandom_range(0, vtx_list.size() - 1)];
  endfunction

  // three vertices, one face, and rays mostly aimed at its inside
  task automatic scene(output int n);
    longint a[3], b[3], c[3], d[3], e1[3], e2[3], pv[3], p[3], o[3];
    int vs, fs, wa, wb, ts, traces;
    vs = $urandom_range(0, 1021);
    fs = $urandom_range(0, 1023);
    for (int k = 0; k < 3; k++) begin
      a[k] = rnd_coord(1 << 18);
      b[k] = rnd_coord(1 << 18);
      c[k] = rnd_coord(1 << 18);
      d[k] = rnd_coord(1 << 13);
      e1[k] = b[k] - a[k];
      e2[k] = c[k] - a[k];
    end
    cross3(d, e2, pv);
    if (dot3(e1, pv) < 0) begin
      put(mk(rti_pkg::CMD_VERTEX, vs + 1, c[0], c[1], c[2], 0, 0, 0));
      put(mk(rti_pkg::CMD_VERTEX, vs + 2, b[0], b[1], b[2], 0, 0, 0));
    end else begin
      put(mk(rti_pkg::CMD_VERTEX, vs + 1, b[0], b[1], b[2], 0, 0, 0));
      put(mk(rti_pkg::CMD_VERTEX, vs + 2, c[0], c[1], c[2], 0, 0, 0));
    end
    put(mk(rti_pkg::CMD_VERTEX, vs, a[0], a[1], a[2], 0, 0, 0));
    put(mk(rti_pkg::CMD_FACE, fs, 0, 0, 0, 0, 0, 0, vs, vs + 1, vs + 2));
    traces = $urandom_range(1, 3);
    for (int i = 0; i < traces; i++) begin
      wa = $urandom_range(5, 125);
      wb = $urandom_range(5, 125);
      ts = $urandom_range(1, 16);
      for (int k = 0; k < 3; k++) begin
        p[k] = a[k] + (e1[k] * wa + e2[k] * wb) / 256;
        o[k] = p[k] - d[k] * ts;
        if ($urandom_range(0, 9) == 0) o[k] += rnd_coord(1 << 17);
      end
      if ($urandom_range(0, 9) == 0)
        put(mk(rti_pkg::CMD_TRACE, fs, o[0], o[1], o[2], -d[0], -d[1], -d[2]));
      else
        put(mk(rti_pkg::CMD_TRACE, fs, o[0], o[1], o[2], d[0], d[1], d[2]));
    end
    n = 4 + traces;
  endtask

  task automatic random_mix(int count);
    int done, n, sel;
    done = 0;
    while (done < count) begin
      sel = $urandom_range(0, 99);
      n = 1;
      if (sel < 60) begin
        scene(n);
      end else if (sel < 75) begin
        put(mk(rti_pkg::CMD_TRACE, face_list[$urandom_range(0, face_list.size() - 1)],
               $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom));
      end else if (sel < 85) begin
        put(mk(rti_pkg::CMD_VERTEX, $urandom_range(0, 1023), $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
      end else if (sel < 93) begin
        put(mk(rti_pkg::CMD_FACE, $urandom_range(0, 1023), $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, rnd_vtx(), rnd_vtx(), rnd_vtx()));
      end else begin
        pending = {pending, mk(rti_pkg::cmd_t'(CMD_NONE), $urandom, $urandom, $urandom,
                               $urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom)};
      end
      done += n;
    end
  endtask

  task automatic settle();
    while (pending.size() > 0 || s_tvalid || hits_due.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == rti_pkg::CFG_DET_MIN) det_min = value;
    else t_min = value[15:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  localparam longint MAXC = 64'sh7F_FFFF;
  localparam longint MINC = -64'sh80_0000;

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = rti_pkg::CFG_DET_MIN;
    cfg_data = '0;
    errors = 0;
    results_seen = 0;
    quiet_cycles = 0;
    det_min = 32'd687195;
    t_min = 16'd1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // extremes, degenerate face, unit triangle that fails the default det_min
    put(mk(rti_pkg::CMD_VERTEX, 0, MAXC, MINC, 0, 0, 0, 0));
    put(mk(rti_pkg::CMD_VERTEX, 1023, MINC, MAXC, MAXC, 0, 0, 0));
    put(mk(rti_pkg::CMD_VERTEX, 1, 0, 0, 0, 0, 0, 0));
    put(mk(rti_pkg::CMD_VERTEX, 2, 1, 0, 0, 0, 0, 0));
    put(mk(rti_pkg::CMD_VERTEX, 3, 0, 1, 0, 0, 0, 0));
    put(mk(rti_pkg::CMD_FACE, 0, 0, 0, 0, 0, 0, 0, 1, 2, 3));
    put(mk(rti_pkg::CMD_FACE, 1023, 0, 0, 0, 0, 0, 0, 0, 1023, 0));
    put(mk(rti_pkg::CMD_FACE, 5, 0, 0, 0, 0, 0, 0, 0, 1023, 1));
    put(mk(rti_pkg::CMD_TRACE, 0, 0, 0, 256, 0, 0, -1));
    put(mk(rti_pkg::CMD_TRACE, 1023, MAXC, MAXC, MAXC, MINC, MINC, MINC));
    put(mk(rti_pkg::CMD_TRACE, 5, MINC, 0, MAXC, MAXC, MINC, 0));
    put(mk(rti_pkg::CMD_TRACE, 5, 0, 0, 0, MAXC, MAXC, MAXC));
    pending = {pending, mk(rti_pkg::cmd_t'(CMD_NONE), 1023, -1, -1, -1, -1, -1, -1,
                           1023, 1023, 1023)};
    random_mix(140);
    settle();

    write_reg(rti_pkg::CFG_DET_MIN, 32'd0);
    write_reg(rti_pkg::CFG_T_MIN, 32'd0);
    put(mk(rti_pkg::CMD_TRACE, 0, 0, 0, MAXC, 0, 0, -1));     // distance saturates
    put(mk(rti_pkg::CMD_TRACE, 0, 0, 0, 256, 0, 0, -1));
    put(mk(rti_pkg::CMD_TRACE, 0, 0, 0, 256, 0, 0, 1));       // back face
    put(mk(rti_pkg::CMD_TRACE, 0, 0, 0, -5, 0, 0, -1));       // behind origin
    put(mk(rti_pkg::CMD_TRACE, 1023, 0, 0, 9, 0, 0, -1));     // zero determinant
    put(mk(rti_pkg::CMD_TRACE, 0, 0, 0, 0, 0, 0, -1));        // on the plane
    random_mix(150);
    settle();

    write_reg(rti_pkg::CFG_DET_MIN, 32'hFFFF_FFFF);
    write_reg(rti_pkg::CFG_T_MIN, 32'd65535);
    put(mk(rti_pkg::CMD_TRACE, 0, 0, 0, 1, 0, 0, -1));
    random_mix(150);
    settle();

    write_reg(rti_pkg::CFG_DET_MIN, 32'd0);
    write_reg(rti_pkg::CFG_T_MIN, 32'd65535);
    put(mk(rti_pkg::CMD_TRACE, 0, 0, 0, 1, 0, 0, -1));        // just above the limit
    put(mk(rti_pkg::CMD_TRACE, 0, 0, 0, 2, 0, 0, -1));
    settle();

    write_reg(rti_pkg::CFG_DET_MIN, $urandom);
    write_reg(rti_pkg::CFG_T_MIN, $urandom_range(0, 300));
    random_mix(300);
    settle();

    if (errors == 0 && hits_due.size() == 0) begin
      $display("ray_triangle_intersect_top regression: pass");
    end else begin
      $display("ray_triangle_intersect_top regression: fail");
    end
    $finish;
  end

endmodule
